### rtl/core/cc20_pkg.sv
// ChaCha20 stream cipher shared types and constants.
// Used by cc20_ctrl, cc20_dp and chacha20_stream_cipher; depends on nothing.
`default_nettype none

package cc20_pkg;

  localparam int unsigned NUM_WORDS = 16;

  localparam logic [31:0] SIGMA [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  localparam logic [31:0] CNT_RESET = 32'd1;

  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  localparam logic [2:0] QR_LAST_COL  = 3'd3;
  localparam logic [2:0] QR_LAST_DIAG = 3'd7;

  localparam logic [2:0] REG_KEY0     = 3'd0;
  localparam logic [2:0] REG_KEY1     = 3'd1;
  localparam logic [2:0] REG_KEY2     = 3'd2;
  localparam logic [2:0] REG_KEY3     = 3'd3;
  localparam logic [2:0] REG_NONCE_LO = 3'd4;
  localparam logic [2:0] REG_NONCE_HI = 3'd5;
  localparam logic [2:0] REG_INIT_CNT = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } cc20_state_e;

  typedef enum logic [1:0] {
    RND_NONE,
    RND_HALF1,
    RND_HALF2
  } cc20_rnd_e;

  typedef enum logic [1:0] {
    PERM_COL,
    PERM_TO_DIAG,
    PERM_FROM_DIAG
  } cc20_perm_e;

  typedef struct packed {
    logic [63:0] key_part_0;
    logic [63:0] key_part_1;
    logic [63:0] key_part_2;
    logic [63:0] key_part_3;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
    logic [31:0] initial_counter;
  } cc20_cfg_t;

  typedef struct packed {
    logic       take_in;
    logic       load_init;
    cc20_rnd_e  rnd_op;
    cc20_perm_e perm;
    logic       feed;
    logic       emit;
  } cc20_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage

`default_nettype wire

### rtl/core/cc20_ctrl.sv
// ChaCha20 controller: state machine, round sequencing and output valid.
// Depends on cc20_pkg; drives cc20_dp through cc20_cmd_t.
`default_nettype none

module cc20_ctrl import cc20_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire logic      pos_zero_i,
  output cc20_cmd_t      cmd_o
);

  localparam int unsigned DRW = $clog2(DOUBLE_ROUNDS + 1);
  localparam logic [DRW-1:0] DR_LAST = DRW'(DOUBLE_ROUNDS - 1);

  cc20_state_e    state_q, state_d;
  logic           half_q;
  logic [2:0]     qr_q;
  logic [DRW-1:0] dr_q;
  logic           out_valid_q;
  logic           out_free;
  logic           round_done;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign round_done = half_q && (qr_q == QR_LAST_DIAG) && (dr_q == DR_LAST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = pos_zero_i ? ST_ROUND : ST_EMIT;
      end
      ST_ROUND: begin
        if (round_done) state_d = ST_FEED;
      end
      ST_FEED: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{take_in: 1'b0, load_init: 1'b0, rnd_op: RND_NONE, perm: PERM_COL,
              feed: 1'b0, emit: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take_in   = in_valid_i;
        cmd_o.load_init = in_valid_i && pos_zero_i;
      end
      ST_ROUND: begin
        cmd_o.rnd_op = half_q ? RND_HALF2 : RND_HALF1;
        if (qr_q == QR_LAST_COL) begin
          cmd_o.perm = PERM_TO_DIAG;
        end else if (qr_q == QR_LAST_DIAG) begin
          cmd_o.perm = PERM_FROM_DIAG;
        end
      end
      ST_FEED: begin
        cmd_o.feed = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = out_free;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      half_q      <= 1'b0;
      qr_q        <= '0;
      dr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ROUND) begin
        half_q <= ~half_q;
        if (half_q) begin
          if (round_done) begin
            qr_q <= '0;
            dr_q <= '0;
          end else begin
            qr_q <= qr_q + 3'd1;
            if (qr_q == QR_LAST_DIAG) dr_q <= dr_q + DRW'(1);
          end
        end
      end
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_idle_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> (!half_q && qr_q == 3'd0 && dr_q == '0))
    else $error("round counters not clear in idle");

  a_feed_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FEED |-> $past(state_q) == ST_ROUND)
    else $error("feed-forward entered without rounds");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("output valid raised outside emit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !(out_valid_q && out_stall_i))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

### rtl/core/cc20_dp.sv
// ChaCha20 datapath: round state, half quarter-round unit, keystream and output.
// Depends on cc20_pkg; controlled by cc20_ctrl.
`default_nettype none

module cc20_dp import cc20_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cc20_cfg_t  cfg_i,
  input  wire cc20_cmd_t  cmd_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            pos_zero_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic [31:0] cnt_q, cnt_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] w_q  [NUM_WORDS];
  logic [31:0] w_d  [NUM_WORDS];
  logic [31:0] ks_q [NUM_WORDS];
  logic [31:0] init_w [NUM_WORDS];
  logic [31:0] qr_w   [NUM_WORDS];
  logic [31:0] p_col  [NUM_WORDS];
  logic [31:0] p_to   [NUM_WORDS];
  logic [31:0] p_from [NUM_WORDS];
  logic [31:0] a1, b1, c1, d1;
  logic [31:0] ks_word;
  logic [7:0]  din_q;
  logic        dlast_q;
  logic [7:0]  ob_q;
  logic        olast_q;

  always_comb begin
    for (int i = 0; i < 4; i++) init_w[i] = SIGMA[i];
    init_w[4]  = cfg_i.key_part_0[31:0];
    init_w[5]  = cfg_i.key_part_0[63:32];
    init_w[6]  = cfg_i.key_part_1[31:0];
    init_w[7]  = cfg_i.key_part_1[63:32];
    init_w[8]  = cfg_i.key_part_2[31:0];
    init_w[9]  = cfg_i.key_part_2[63:32];
    init_w[10] = cfg_i.key_part_3[31:0];
    init_w[11] = cfg_i.key_part_3[63:32];
    init_w[12] = cnt_q;
    init_w[13] = cfg_i.nonce_low[31:0];
    init_w[14] = cfg_i.nonce_low[63:32];
    init_w[15] = cfg_i.nonce_high;
  end

  always_comb begin
    a1 = w_q[0] + w_q[4];
    d1 = (cmd_i.rnd_op == RND_HALF2) ? rotl(w_q[12] ^ a1, ROT_C) : rotl(w_q[12] ^ a1, ROT_A);
    c1 = w_q[8] + d1;
    b1 = (cmd_i.rnd_op == RND_HALF2) ? rotl(w_q[4] ^ c1, ROT_D) : rotl(w_q[4] ^ c1, ROT_B);
    qr_w     = w_q;
    qr_w[0]  = a1;
    qr_w[4]  = b1;
    qr_w[8]  = c1;
    qr_w[12] = d1;
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        p_col[4*r+c]  = qr_w[4*r + ((c + 1) & 3)];
        p_to[4*r+c]   = qr_w[4*r + ((c + 1 + r) & 3)];
        p_from[4*r+c] = qr_w[4*r + ((c + 5 - r) & 3)];
      end
    end
  end

  always_comb begin
    w_d = w_q;
    if (cmd_i.load_init) begin
      w_d = init_w;
    end else begin
      case (cmd_i.rnd_op)
        RND_HALF1: w_d = qr_w;
        RND_HALF2: begin
          case (cmd_i.perm)
            PERM_TO_DIAG:   w_d = p_to;
            PERM_FROM_DIAG: w_d = p_from;
            default:        w_d = p_col;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (cmd_i.feed) cnt_d = cnt_q + 32'd1;
    if (cmd_i.emit) begin
      if (dlast_q) begin
        cnt_d = cfg_i.initial_counter;
        pos_d = '0;
      end else begin
        pos_d = pos_q + 6'd1;
      end
    end
  end

  assign ks_word = ks_q[pos_q[5:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
      pos_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (cmd_i.feed) begin
      for (int k = 0; k < NUM_WORDS; k++) ks_q[k] <= w_q[k] + init_w[k];
    end
    if (cmd_i.take_in) begin
      din_q   <= data_byte_i;
      dlast_q <= last_byte_i;
    end
    if (cmd_i.emit) begin
      ob_q    <= din_q ^ ks_word[8*pos_q[1:0] +: 8];
      olast_q <= dlast_q;
    end
  end

  assign pos_zero_o = (pos_q == 6'd0);
  assign out_byte_o = ob_q;
  assign out_last_o = olast_q;

endmodule

`default_nettype wire

### rtl/core/chacha20_stream_cipher.sv
// ChaCha20 stream cipher top level: configuration registers and the
// controller/datapath pair. Depends on cc20_pkg, cc20_ctrl and cc20_dp.
//
// Usage: each input transfer carries one data byte and a last flag; each
// output transfer returns the byte XORed with keystream plus the same flag.
// Key, nonce and initial counter sit behind the APB port (64-bit data,
// register i at byte address 8*i); the user must write them only while the
// block is idle, which the block itself does not enforce. A byte within a
// keystream block passes through the emit state into the output register
// once that register is free. The first byte of each 64-byte block (and the
// first byte after a byte marked last) waits for the block build: DOUBLE_ROUNDS
// double rounds on the shared half quarter-round unit, then the feed-forward
// step and the output step. The block takes no new input byte until the
// previous one has gone to the output register.
// Reset clears the byte position and loads the block counter with 1.
// While the receiver stalls, the result holds in the output register; the
// block takes one more input transfer and holds its result until the
// output register frees up.
`default_nettype none

module chacha20_stream_cipher import cc20_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  cc20_cfg_t  cfg_q;
  cc20_cmd_t  cmd;
  logic       pos_zero;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{key_part_0: '0, key_part_1: '0, key_part_2: '0, key_part_3: '0,
                 nonce_low: '0, nonce_high: '0, initial_counter: CNT_RESET};
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY0:     cfg_q.key_part_0      <= pwdata;
        REG_KEY1:     cfg_q.key_part_1      <= pwdata;
        REG_KEY2:     cfg_q.key_part_2      <= pwdata;
        REG_KEY3:     cfg_q.key_part_3      <= pwdata;
        REG_NONCE_LO: cfg_q.nonce_low       <= pwdata;
        REG_NONCE_HI: cfg_q.nonce_high      <= pwdata[31:0];
        REG_INIT_CNT: cfg_q.initial_counter <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY0:     prdata = cfg_q.key_part_0;
      REG_KEY1:     prdata = cfg_q.key_part_1;
      REG_KEY2:     prdata = cfg_q.key_part_2;
      REG_KEY3:     prdata = cfg_q.key_part_3;
      REG_NONCE_LO: prdata = cfg_q.nonce_low;
      REG_NONCE_HI: prdata = {32'd0, cfg_q.nonce_high};
      REG_INIT_CNT: prdata = {32'd0, cfg_q.initial_counter};
      default:      prdata = '0;
    endcase
  end

  cc20_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pos_zero_i (pos_zero),
    .cmd_o      (cmd)
  );

  cc20_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .pos_zero_o (pos_zero),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for chacha20_stream_cipher: sends data bytes in messages of random
// length, checks every returned byte against its own keystream calculation, and reprograms
// key, nonce and counter between phases. Depends on cc20_pkg and the cipher RTL.
module testbench;
  import cc20_pkg::*;

  localparam int unsigned DBL_ROUNDS  = 10;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned PHASE_BYTES = 135;
  localparam logic [2:0]  REG_UNUSED  = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_xfer_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = 6'd0;
  logic [63:0] pwdata = 64'd0;
  logic [63:0] prdata;
  logic        pready;

  chacha20_stream_cipher #(.DOUBLE_ROUNDS(DBL_ROUNDS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i), .last_byte_i(last_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_byte_o(out_byte_o), .out_last_o(out_last_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  byte_xfer_t  plain_q[$];
  byte_xfer_t  cipher_q[$];

  logic [63:0] key_w [4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] init_ctr;
  logic [31:0] blk_cnt;
  logic [5:0]  byte_pos;
  logic [31:0] ks_word [16];
  logic [31:0] mix_w [16];

  bit          in_taken = 1'b0;
  bit          idle_on = 1'b1;
  int unsigned gap_pct = 30;
  int unsigned stall_pct = 30;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;
  byte_xfer_t  next_in;
  byte_xfer_t  want_out;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    logic [63:0] dbl;
    dbl = {v, v};
    return dbl[(63 - s) -: 32];
  endfunction

  function automatic void mix_quarter(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void build_keystream();
    logic [31:0] seed [16];
    seed[0]  = 32'h61707865;
    seed[1]  = 32'h3320646e;
    seed[2]  = 32'h79622d32;
    seed[3]  = 32'h6b206574;
    for (int k = 0; k < 4; k++) begin
      seed[4 + 2 * k] = key_w[k][31:0];
      seed[5 + 2 * k] = key_w[k][63:32];
    end
    seed[12] = blk_cnt;
    seed[13] = nonce_lo[31:0];
    seed[14] = nonce_lo[63:32];
    seed[15] = nonce_hi;
    for (int k = 0; k < 16; k++) mix_w[k] = seed[k];
    for (int r = 0; r < DBL_ROUNDS; r++) begin
      mix_quarter(0, 4, 8, 12);
      mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14);
      mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15);
      mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);
      mix_quarter(3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) ks_word[k] = mix_w[k] + seed[k];
  endfunction

  function automatic void encrypt_byte(input logic [7:0] d, input logic l);
    logic [31:0] w;
    byte_xfer_t  e;
    if (byte_pos == 6'd0) begin
      build_keystream();
      blk_cnt = blk_cnt + 32'd1;
    end
    w = ks_word[byte_pos[5:2]];
    e.data = d ^ w[byte_pos[1:0] * 8 +: 8];
    e.last = l;
    cipher_q.push_back(e);
    if (l) begin
      blk_cnt  = init_ctr;
      byte_pos = 6'd0;
    end else begin
      byte_pos = byte_pos + 6'd1;
    end
  endfunction

  // input side: accept at the rising edge, present at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      in_taken = 1'b1;
      encrypt_byte(data_byte_i, last_byte_i);
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(99, 0) < gap_pct) begin
        gap_left = $urandom_range(12, 0);
        in_valid_i <= 1'b0;
      end else if (plain_q.size() > 0) begin
        next_in = plain_q.pop_front();
        data_byte_i <= next_in.data;
        last_byte_i <= next_in.last;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: stall bursts and the long hold
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(99, 0) < stall_pct) begin
      stall_left = $urandom_range(12, 0);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected output transfer: byte %02h last %0b", out_byte_o, out_last_o);
      end else begin
        want_out = cipher_q.pop_front();
        if (out_byte_o !== want_out.data || out_last_o !== want_out.last) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch at %0t: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want_out.data, want_out.last, out_byte_o, out_last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_KEY0:     key_w[0] = val;
      REG_KEY1:     key_w[1] = val;
      REG_KEY2:     key_w[2] = val;
      REG_KEY3:     key_w[3] = val;
      REG_NONCE_LO: nonce_lo = val;
      REG_NONCE_HI: nonce_hi = val[31:0];
      REG_INIT_CNT: init_ctr = val[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (plain_q.size() != 0 || in_valid_i || cipher_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] d, input logic l);
    byte_xfer_t it;
    it.data = d;
    it.last = l;
    plain_q.push_back(it);
  endtask

  task automatic queue_messages(input int unsigned n, input bit long_only);
    int unsigned cnt;
    int unsigned len;
    int unsigned r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99, 0);
      if (long_only) len = $urandom_range(200, 65);
      else if (r < 35) len = $urandom_range(8, 1);
      else if (r < 75) len = $urandom_range(70, 9);
      else len = $urandom_range(150, 60);
      for (int unsigned k = 0; k < len && cnt < n; k++) begin
        push_byte(8'($urandom_range(255, 0)), k == len - 1);
        cnt++;
      end
    end
  endtask

  task automatic program_phase(input int ph);
    logic [2:0] ri;
    for (int i = 0; i < 7; i++) begin
      ri = 3'(i);
      case (ph)
        1: write_reg(ri, (ri == REG_NONCE_HI || ri == REG_INIT_CNT) ?
                         {$urandom, 32'hFFFF_FFFF} : 64'hFFFF_FFFF_FFFF_FFFF);
        2: write_reg(ri, 64'd0);
        3: if ($urandom_range(1, 0)) write_reg(ri, {$urandom, $urandom});
        5: if (ri == REG_INIT_CNT) write_reg(ri, {$urandom, $urandom});
        default: write_reg(ri, {$urandom, $urandom});
      endcase
    end
    if (ph == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  initial begin
    for (int k = 0; k < 4; k++) key_w[k] = 64'd0;
    nonce_lo = 64'd0;
    nonce_hi = 32'd0;
    init_ctr = 32'd1;
    blk_cnt  = 32'd1;
    byte_pos = 6'd0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h5A, 1'b1);
    for (int k = 0; k < 10; k++) push_byte(8'($urandom_range(255, 0)), k == 9);

    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      program_phase(ph);
      case (ph)
        0: begin idle_on = 1'b1; gap_pct = 20; stall_pct = 20; end
        1: begin idle_on = 1'b1; gap_pct = 40; stall_pct = 40; end
        2: begin idle_on = 1'b1; gap_pct = 25; stall_pct = 15; end
        4: begin idle_on = 1'b1; gap_pct = 50; stall_pct = 50; end
        5: begin idle_on = 1'b1; gap_pct = 10; stall_pct = 30; end
        default: idle_on = 1'b0;
      endcase
      queue_messages(PHASE_BYTES, ph == 1);
      if (ph == 2) hold_req = 1'b1;
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/cc20_pkg.sv
rtl/core/cc20_ctrl.sv
rtl/core/cc20_dp.sv
rtl/core/chacha20_stream_cipher.sv
dv/testbench.sv
